// ----- rtl/triangle_piecewise_linear_eval_defines.svh -----
// Assertion macros shared by the triangle evaluator RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef TRIANGLE_PIECEWISE_LINEAR_EVAL_DEFINES_SVH
`define TRIANGLE_PIECEWISE_LINEAR_EVAL_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TPLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TPLE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tple_pkg.sv -----
// Shared constants, types and helpers for the triangle evaluator.
// No dependencies; used by tple_scan, tple_plane and the top level.
package tple_pkg;

    localparam int MAX_TRIANGLES   = 64;
    localparam int FRAC_BITS       = 16;
    localparam int WORDS_PER_ENTRY = 9;
    localparam int WORD_W          = 32;
    localparam int ENTRY_W         = 6;
    localparam int SEL_W           = 4;
    localparam int CFG_W           = 7;
    localparam int ROW_W           = $clog2(MAX_TRIANGLES);
    localparam int CNT_W           = $clog2(MAX_TRIANGLES + 1);
    localparam int DIFF_W          = WORD_W + 1;
    localparam int PROD_W          = 2 * DIFF_W;

    // item kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_TRI_IN_USE = 1'b0;

    // coefficient slots within an entry
    localparam int SLOT_A = 6;
    localparam int SLOT_B = 7;
    localparam int SLOT_C = 8;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [WORDS_PER_ENTRY-1:0][WORD_W-1:0] tple_row_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
    } tple_coef_t;

    // one scanned entry leaving the edge-test pipeline
    typedef struct packed {
        logic              valid;
        logic              match;
        logic [ROW_W-1:0]  entry;
        tple_coef_t        coef;
    } tple_hit_t;

    // exact 33-bit difference of two signed words
    function automatic diff_t wdiff(word_t p, word_t q);
        return $signed({p[WORD_W-1], p}) - $signed({q[WORD_W-1], q});
    endfunction

endpackage

// ----- rtl/tple_scan.sv -----
// Edge-test pipeline: one table row in per cycle, containment verdict out.
// Depends on tple_pkg. Three register stages: differences, products, compare.
module tple_scan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        flush,
    input  logic                        in_valid,
    input  logic [tple_pkg::ROW_W-1:0]  in_entry,
    input  tple_pkg::tple_row_t         in_row,
    input  tple_pkg::word_t             px,
    input  tple_pkg::word_t             py,
    output tple_pkg::tple_hit_t         hit
);
    import tple_pkg::*;

    // stage A: edge differences
    logic             a_valid_reg;
    logic [ROW_W-1:0] a_entry_reg;
    tple_coef_t       a_coef_reg;
    diff_t            d_px_reg [3];
    diff_t            d_uy_reg [3];
    diff_t            d_ux_reg [3];
    diff_t            d_py_reg [3];

    // stage B: cross products
    logic             b_valid_reg;
    logic [ROW_W-1:0] b_entry_reg;
    tple_coef_t       b_coef_reg;
    prod_t            l_reg [3];
    prod_t            r_reg [3];

    // stage C: verdict
    tple_hit_t        hit_reg;
    logic [2:0]       neg;

    generate
        for (genvar k = 0; k < 3; k++) begin : g_edge
            localparam int J = (k + 1) % 3;
            // edge from vertex k to vertex J
            always_ff @(posedge aclk) begin
                d_px_reg[k] <= wdiff(px, word_t'(in_row[2*J]));
                d_uy_reg[k] <= wdiff(word_t'(in_row[2*k+1]), word_t'(in_row[2*J+1]));
                d_ux_reg[k] <= wdiff(word_t'(in_row[2*k]), word_t'(in_row[2*J]));
                d_py_reg[k] <= wdiff(py, word_t'(in_row[2*J+1]));
                l_reg[k]    <= d_px_reg[k] * d_uy_reg[k];
                r_reg[k]    <= d_ux_reg[k] * d_py_reg[k];
            end
            assign neg[k] = l_reg[k] < r_reg[k];
        end
    endgenerate

    // control: flush drops everything in flight
    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            hit_reg.valid <= 1'b0;
        end else begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            hit_reg.valid <= b_valid_reg;
        end
    end

    // payload alongside the valid bits
    always_ff @(posedge aclk) begin
        a_entry_reg   <= in_entry;
        a_coef_reg.a  <= word_t'(in_row[SLOT_A]);
        a_coef_reg.b  <= word_t'(in_row[SLOT_B]);
        a_coef_reg.c  <= word_t'(in_row[SLOT_C]);
        b_entry_reg   <= a_entry_reg;
        b_coef_reg    <= a_coef_reg;
        hit_reg.entry <= b_entry_reg;
        hit_reg.coef  <= b_coef_reg;
        // all three negative or all three non-negative
        hit_reg.match <= (neg[0] == neg[1]) && (neg[1] == neg[2]);
    end

    assign hit = hit_reg;

endmodule

// ----- rtl/tple_plane.sv -----
// Plane value unit: a*x + b*y + c with floor scaling and 32-bit saturation.
// Depends on tple_pkg. Three register stages, one start pulse per query.
module tple_plane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  tple_pkg::tple_coef_t coef,
    input  tple_pkg::word_t      px,
    input  tple_pkg::word_t      py,
    output logic                 done,
    output tple_pkg::word_t      value
);
    import tple_pkg::*;

    localparam int MUL_W = 2 * WORD_W;
    localparam int SUM_W = MUL_W + 1;
    localparam int TOT_W = SUM_W + 1;

    logic                    v1_reg, v2_reg, v3_reg;
    logic signed [MUL_W-1:0] ax_reg, by_reg;
    word_t                   c1_reg, c2_reg;
    logic signed [SUM_W-1:0] sum_full, shifted_reg;
    logic signed [TOT_W-1:0] total;
    word_t                   value_reg;
    logic                    ovf;

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // exact sum, floor shift, then add c and clamp
    assign sum_full = SUM_W'(ax_reg) + SUM_W'(by_reg);
    assign total    = TOT_W'(shifted_reg) + TOT_W'(c2_reg);
    assign ovf      = (total[TOT_W-1:WORD_W-1] != '0) && (total[TOT_W-1:WORD_W-1] != '1);

    always_ff @(posedge aclk) begin
        ax_reg      <= coef.a * px;
        by_reg      <= coef.b * py;
        c1_reg      <= coef.c;
        shifted_reg <= sum_full >>> FRAC_BITS;
        c2_reg      <= c1_reg;
        if (ovf) begin
            value_reg <= total[TOT_W-1] ? {1'b1, {(WORD_W-1){1'b0}}}
                                        : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            value_reg <= total[WORD_W-1:0];
        end
    end

    assign done  = v3_reg;
    assign value = value_reg;

endmodule

// ----- rtl/triangle_piecewise_linear_eval.sv -----
// Piecewise-linear triangle evaluator: table memory, scan control, outputs.
// Depends on tple_pkg, tple_scan, tple_plane and the assertion header.
//
// Usage: the s_ channel takes one beat per item. tuser selects the kind:
// a write beat stores one word of one table entry, an evaluate beat
// carries a point. Every beat yields exactly one m_ beat, in order.
// An evaluate beat scans entries 0..count-1 (count = triangles_in_use,
// capped at 64), one row read from the entry memory per cycle, and stops
// at the first containing triangle.
// A write or an empty scan goes straight to the output register; a hit
// passes through the scan pipeline and then the plane unit, and a miss
// through the scan of all count entries. Items are worked one at a time.
// The result sits in an output register, so the next beat is accepted
// while m_tready is low; a finished result then waits until the output
// register frees up. Reset clears triangles_in_use and all control
// state; the table is undefined until written and needs no clearing pass.
`include "triangle_piecewise_linear_eval_defines.svh"

module triangle_piecewise_linear_eval (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,  // entry_index, word_select, word_value, point_x, point_y
    input  logic [0:0]   s_tuser,  // operation
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,  // result_value, matched_entry
    output logic [0:0]   m_tuser,  // inside_found
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tple_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_PLANE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // input fields
    logic               in_op;
    logic [ENTRY_W-1:0] in_entry;
    logic [SEL_W-1:0]   in_slot;
    word_t              in_word, in_px, in_py;
    logic               in_acc;

    assign in_op    = s_tuser[0];
    assign in_entry = s_tdata[5:0];
    assign in_slot  = s_tdata[9:6];
    assign in_word  = s_tdata[41:10];
    assign in_px    = s_tdata[73:42];
    assign in_py    = s_tdata[105:74];

    // registers
    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] tiu_reg;
    word_t            px_reg, px_next, py_reg, py_next;
    logic [CNT_W-1:0] count_reg, count_next, rd_idx_reg, rd_idx_next, cnt_eff;
    word_t            res_value_reg, res_value_next;
    logic             res_found_reg, res_found_next;
    logic [ROW_W-1:0] res_entry_reg, res_entry_next;
    logic             m_valid_reg, m_valid_next;
    word_t            m_value_reg, m_value_next;
    logic             m_found_reg, m_found_next;
    logic [ROW_W-1:0] m_entry_reg, m_entry_next;
    logic             rd_issue_reg;
    logic [ROW_W-1:0] rd_entry_reg;

    // entry memory, one row per triangle
    tple_row_t        mem [MAX_TRIANGLES];
    tple_row_t        rd_row_reg;
    logic             wr_en, rd_en, flush, plane_start, plane_done, last_entry;
    word_t            plane_value;
    tple_hit_t        hit;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign cnt_eff  = (32'(tiu_reg) > MAX_TRIANGLES) ? CNT_W'(MAX_TRIANGLES)
                                                     : CNT_W'(tiu_reg);
    assign last_entry = (CNT_W'(hit.entry) + CNT_W'(1)) == count_reg;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TRI_IN_USE) ? 32'(tiu_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiu_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_TRI_IN_USE) begin
            tiu_reg <= pwdata[CFG_W-1:0];
        end
    end

    // memory: one word write, one row read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[ROW_W'(in_entry)][in_slot] <= in_word;
        end
        if (rd_en) begin
            rd_row_reg <= mem[rd_idx_reg[ROW_W-1:0]];
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        res_value_next = res_value_reg;
        res_found_next = res_found_reg;
        res_entry_next = res_entry_reg;
        m_valid_next   = m_valid_reg;
        m_value_next   = m_value_reg;
        m_found_next   = m_found_reg;
        m_entry_next   = m_entry_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        flush          = 1'b0;
        plane_start    = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    res_value_next = '0;
                    res_found_next = 1'b0;
                    res_entry_next = '0;
                    if (in_op == OP_WRITE) begin
                        wr_en = (32'(in_entry) < MAX_TRIANGLES) &&
                                (32'(in_slot) < WORDS_PER_ENTRY);
                        state_next = ST_DONE;
                    end else begin
                        px_next     = in_px;
                        py_next     = in_py;
                        count_next  = cnt_eff;
                        rd_idx_next = '0;
                        state_next  = (cnt_eff == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit.valid && hit.match) begin
                    // first containing entry: drop the rest, evaluate the plane
                    flush          = 1'b1;
                    plane_start    = 1'b1;
                    res_entry_next = hit.entry;
                    state_next     = ST_PLANE;
                end else if (hit.valid && last_entry) begin
                    state_next = ST_DONE;
                end
                if (!flush && rd_idx_reg < count_reg) begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
            end
            ST_PLANE: begin
                if (plane_done) begin
                    res_value_next = plane_value;
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_value_next = res_value_reg;
                    m_found_next = res_found_reg;
                    m_entry_next = res_entry_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            rd_issue_reg <= 1'b0;
            rd_idx_reg   <= '0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            rd_issue_reg <= rd_en;
            rd_idx_reg   <= rd_idx_next;
            count_reg    <= count_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        res_value_reg <= res_value_next;
        res_found_reg <= res_found_next;
        res_entry_reg <= res_entry_next;
        m_value_reg   <= m_value_next;
        m_found_reg   <= m_found_next;
        m_entry_reg   <= m_entry_next;
        rd_entry_reg  <= rd_idx_reg[ROW_W-1:0];
    end

    tple_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flush    (flush),
        .in_valid (rd_issue_reg),
        .in_entry (rd_entry_reg),
        .in_row   (rd_row_reg),
        .px       (px_reg),
        .py       (py_reg),
        .hit      (hit)
    );

    tple_plane u_plane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (plane_start),
        .coef     (hit.coef),
        .px       (px_reg),
        .py       (py_reg),
        .done     (plane_done),
        .value    (plane_value)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, ENTRY_W'(m_entry_reg), m_value_reg};
    assign m_tuser  = m_found_reg;

    // checks
    `TPLE_ASSERT_IMP(a_miss_zero, m_valid_reg && !m_found_reg, m_value_reg == '0 && m_entry_reg == '0, "miss beat carries a nonzero payload")
    `TPLE_ASSERT_IMP(a_hit_in_scan, hit.valid, state_reg == ST_SCAN, "scan verdict outside a scan")
    `TPLE_ASSERT_IMP(a_plane_in_plane, plane_done, state_reg == ST_PLANE, "plane result outside plane state")
    `TPLE_ASSERT_NXT(a_done_emits, state_reg == ST_DONE && (!m_valid_reg || m_tready), m_valid_reg && state_reg == ST_IDLE, "finished result not moved to output")

endmodule
